FILE: hw/rtl/aea_pkg.sv
package aea_pkg;

    localparam logic [1:0] CMD_ALLOC_FIRST = 2'd0;
    localparam logic [1:0] CMD_ALLOC_LAST  = 2'd1;
    localparam logic [1:0] CMD_FREE        = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_BAD   = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] req_size;
        logic [4:0]  align_log2;
        logic [31:0] free_address;
    } req_t;

    typedef struct packed {
        logic [31:0] address;
        logic [1:0]  status;
        logic [31:0] total_free;
    } rsp_t;

endpackage

FILE: hw/rtl/aea_ram.sv
module aea_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/aligned_extent_allocator.sv
// An allocate checks the request, reads, rounds and compares one extent at a time, then
// acts and shifts entries; a free reads the extents below the address and the first one
// above it, then checks, merges and shifts; a bad request goes straight to the result.
// Throughput: one request at a time; busy stays high until the result strobe.
// The table walk sets the pace: one dual-port RAM read and one add/compare per step.
// Reset (rst_n low, asynchronous) empties the table and clears the free total at once.
// The result is on the result port for one cycle with done high; the receiver cannot stall.
module aligned_extent_allocator #(
    parameter int MAX_EXTENTS  = 32,
    parameter int ADDR_WIDTH   = 32,
    parameter int GRANULE_LOG2 = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  aea_pkg::req_t req,
    output logic          busy,
    output logic          done,
    output aea_pkg::rsp_t result
);
    import aea_pkg::*;

    // Index and count widths for the extent table
    localparam int IW  = $clog2(MAX_EXTENTS);
    localparam int CNW = $clog2(MAX_EXTENTS + 1);
    // Working width: wide enough for any address plus a length without overflow
    localparam int CW  = ((ADDR_WIDTH > 32) ? ADDR_WIDTH : 32) + 2;
    localparam int EW  = ADDR_WIDTH + 32;

    localparam logic [CNW-1:0] CNT_MAX = CNW'(MAX_EXTENTS);
    localparam logic [CNW-1:0] CNT_ONE = CNW'(1);
    localparam logic [31:0]    GMASK   = 32'((64'd1 << GRANULE_LOG2) - 64'd1);
    localparam logic [CW-1:0]  SPACE   = CW'(1) << ADDR_WIDTH;

    // Sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_ARD   = 4'd2;
    localparam logic [3:0] S_AEV   = 4'd3;
    localparam logic [3:0] S_ACMP  = 4'd4;
    localparam logic [3:0] S_AACT  = 4'd5;
    localparam logic [3:0] S_FRD   = 4'd6;
    localparam logic [3:0] S_FEV   = 4'd7;
    localparam logic [3:0] S_FCHK  = 4'd8;
    localparam logic [3:0] S_SHRD  = 4'd9;
    localparam logic [3:0] S_SHWR  = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    logic [3:0]            state_reg, state_next;
    req_t                  req_reg, req_next;
    logic [CNW-1:0]        count_reg, count_next;
    logic [31:0]           total_reg, total_next;
    logic [CNW-1:0]        newcount_reg, newcount_next;
    logic [31:0]           newtotal_reg, newtotal_next;
    logic [1:0]            status_reg, status_next;
    logic [31:0]           addr_out_reg, addr_out_next;
    logic [IW-1:0]         idx_reg, idx_next;
    logic [CNW-1:0]        n_reg, n_next;
    logic [CNW-1:0]        pos_reg, pos_next;
    logic [ADDR_WIDTH-1:0] cur_s_reg, cur_s_next;
    logic [CW-1:0]         aligned_reg, aligned_next;
    logic [CW-1:0]         end_reg, end_next;
    logic [CW-1:0]         sum_reg, sum_next;
    logic [ADDR_WIDTH-1:0] prev_s_reg, prev_s_next;
    logic [31:0]           prev_len_reg, prev_len_next;
    logic                  has_prev_reg, has_prev_next;
    logic [ADDR_WIDTH-1:0] next_s_reg, next_s_next;
    logic [31:0]           next_len_reg, next_len_next;
    logic                  has_next_reg, has_next_next;
    logic                  sh_up_reg, sh_up_next;
    logic [IW-1:0]         sh_dst_reg, sh_dst_next;
    logic [CNW-1:0]        sh_n_reg, sh_n_next;
    logic                  fin_we_reg, fin_we_next;
    logic [IW-1:0]         fin_addr_reg, fin_addr_next;
    logic [EW-1:0]         fin_data_reg, fin_data_next;
    logic                  done_reg, done_next;
    rsp_t                  result_reg, result_next;

    logic                  ram_we;
    logic [IW-1:0]         ram_waddr;
    logic [EW-1:0]         ram_wdata;
    logic [IW-1:0]         ram_raddr;
    logic [EW-1:0]         ram_rdata;

    logic [ADDR_WIDTH-1:0] rd_s;
    logic [31:0]           rd_len;
    logic [CW-1:0]         size_cw;
    logic [CW-1:0]         faddr_cw;
    logic [CW-1:0]         amask;
    logic [CW-1:0]         left_cw;
    logic [CW-1:0]         prev_end;
    logic [CW-1:0]         f_end;
    logic [32:0]           total_sum;
    logic                  from_top;

    assign rd_s     = ram_rdata[EW-1:32];
    assign rd_len   = ram_rdata[31:0];
    assign size_cw  = {{(CW-32){1'b0}}, req_reg.req_size};
    assign faddr_cw = {{(CW-32){1'b0}}, req_reg.free_address};
    assign amask    = (CW'(1) << req_reg.align_log2) - CW'(1);
    assign left_cw  = end_reg - sum_reg;
    assign prev_end = {{(CW-ADDR_WIDTH){1'b0}}, prev_s_reg} + {{(CW-32){1'b0}}, prev_len_reg};
    assign f_end    = faddr_cw + size_cw;
    assign total_sum = {1'b0, total_reg} + {1'b0, req_reg.req_size};
    assign from_top = (req_reg.cmd == CMD_ALLOC_LAST);

    aea_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_EXTENTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        req_next      = req_reg;
        count_next    = count_reg;
        total_next    = total_reg;
        newcount_next = newcount_reg;
        newtotal_next = newtotal_reg;
        status_next   = status_reg;
        addr_out_next = addr_out_reg;
        idx_next      = idx_reg;
        n_next        = n_reg;
        pos_next      = pos_reg;
        cur_s_next    = cur_s_reg;
        aligned_next  = aligned_reg;
        end_next      = end_reg;
        sum_next      = sum_reg;
        prev_s_next   = prev_s_reg;
        prev_len_next = prev_len_reg;
        has_prev_next = has_prev_reg;
        next_s_next   = next_s_reg;
        next_len_next = next_len_reg;
        has_next_next = has_next_reg;
        sh_up_next    = sh_up_reg;
        sh_dst_next   = sh_dst_reg;
        sh_n_next     = sh_n_reg;
        fin_we_next   = fin_we_reg;
        fin_addr_next = fin_addr_reg;
        fin_data_next = fin_data_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = '0;
        ram_raddr     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next   = req;
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                // Default outcome: failure, no table change
                newcount_next = count_reg;
                newtotal_next = total_reg;
                addr_out_next = '0;
                fin_we_next   = 1'b0;
                status_next   = ST_BAD;
                state_next    = S_DONE;
                if (req_reg.cmd == CMD_ALLOC_FIRST || req_reg.cmd == CMD_ALLOC_LAST)
                begin
                    if (req_reg.req_size == 32'd0 || (req_reg.req_size & GMASK) != 32'd0 ||
                        32'(req_reg.align_log2) < 32'(GRANULE_LOG2))
                    begin
                        status_next = ST_BAD;
                    end
                    else if (count_reg == '0)
                    begin
                        status_next = ST_NOFIT;
                    end
                    else
                    begin
                        n_next     = '0;
                        idx_next   = from_top ? IW'(count_reg - CNT_ONE) : '0;
                        state_next = S_ARD;
                    end
                end
                else if (req_reg.cmd == CMD_FREE)
                begin
                    if (req_reg.req_size == 32'd0 || (req_reg.req_size & GMASK) != 32'd0 ||
                        (req_reg.free_address & GMASK) != 32'd0 || faddr_cw >= SPACE ||
                        f_end > SPACE || total_sum[32])
                    begin
                        status_next = ST_BAD;
                    end
                    else
                    begin
                        pos_next      = '0;
                        has_prev_next = 1'b0;
                        has_next_next = 1'b0;
                        state_next    = S_FRD;
                    end
                end
            end

            S_ARD:
            begin
                ram_raddr  = idx_reg;
                state_next = S_AEV;
            end

            S_AEV:
            begin
                // Round the extent start up to the alignment; note the extent end
                cur_s_next    = rd_s;
                aligned_next  = ({{(CW-ADDR_WIDTH){1'b0}}, rd_s} + amask) & ~amask;
                end_next      = {{(CW-ADDR_WIDTH){1'b0}}, rd_s} + {{(CW-32){1'b0}}, rd_len};
                state_next    = S_ACMP;
            end

            S_ACMP:
            begin
                sum_next = aligned_reg + size_cw;
                if (aligned_reg + size_cw <= end_reg)
                begin
                    state_next = S_AACT;
                end
                else if (n_reg == count_reg - CNT_ONE)
                begin
                    status_next = ST_NOFIT;
                    state_next  = S_DONE;
                end
                else
                begin
                    n_next     = n_reg + CNT_ONE;
                    idx_next   = from_top ? idx_reg - IW'(1) : idx_reg + IW'(1);
                    state_next = S_ARD;
                end
            end

            S_AACT:
            begin
                status_next   = ST_OK;
                addr_out_next = aligned_reg[31:0];
                newtotal_next = total_reg - req_reg.req_size;
                newcount_next = count_reg;
                sh_n_next     = '0;
                state_next    = S_DONE;
                if (aligned_reg == {{(CW-ADDR_WIDTH){1'b0}}, cur_s_reg})
                begin
                    if (left_cw != '0)
                    begin
                        // Shrink from the front
                        ram_we    = 1'b1;
                        ram_waddr = idx_reg;
                        ram_wdata = {sum_reg[ADDR_WIDTH-1:0], left_cw[31:0]};
                    end
                    else
                    begin
                        // Exact fit: drop the entry
                        newcount_next = count_reg - CNT_ONE;
                        sh_up_next    = 1'b0;
                        sh_dst_next   = idx_reg;
                        sh_n_next     = count_reg - CNT_ONE - CNW'(idx_reg);
                        if (count_reg - CNT_ONE - CNW'(idx_reg) != '0)
                        begin
                            state_next = S_SHRD;
                        end
                    end
                end
                else
                begin
                    if (left_cw != '0 && count_reg == CNT_MAX)
                    begin
                        status_next   = ST_FULL;
                        addr_out_next = '0;
                        newtotal_next = total_reg;
                    end
                    else
                    begin
                        // Keep the padding in place
                        ram_we    = 1'b1;
                        ram_waddr = idx_reg;
                        ram_wdata = {cur_s_reg, 32'(aligned_reg - {{(CW-ADDR_WIDTH){1'b0}},
                                                                   cur_s_reg})};
                        if (left_cw != '0)
                        begin
                            // Insert the remainder behind it
                            newcount_next = count_reg + CNT_ONE;
                            fin_we_next   = 1'b1;
                            fin_addr_next = idx_reg + IW'(1);
                            fin_data_next = {sum_reg[ADDR_WIDTH-1:0], left_cw[31:0]};
                            sh_up_next    = 1'b1;
                            sh_dst_next   = IW'(count_reg);
                            sh_n_next     = count_reg - CNW'(idx_reg) - CNT_ONE;
                            if (count_reg - CNW'(idx_reg) - CNT_ONE != '0)
                            begin
                                state_next = S_SHRD;
                            end
                        end
                    end
                end
            end

            S_FRD:
            begin
                if (pos_reg == count_reg)
                begin
                    state_next = S_FCHK;
                end
                else
                begin
                    ram_raddr  = IW'(pos_reg);
                    state_next = S_FEV;
                end
            end

            S_FEV:
            begin
                if ({{(CW-ADDR_WIDTH){1'b0}}, rd_s} < faddr_cw)
                begin
                    prev_s_next   = rd_s;
                    prev_len_next = rd_len;
                    has_prev_next = 1'b1;
                    pos_next      = pos_reg + CNT_ONE;
                    state_next    = S_FRD;
                end
                else
                begin
                    next_s_next   = rd_s;
                    next_len_next = rd_len;
                    has_next_next = 1'b1;
                    state_next    = S_FCHK;
                end
            end

            S_FCHK:
            begin
                state_next    = S_DONE;
                newcount_next = count_reg;
                sh_n_next     = '0;
                if ((has_prev_reg && prev_end > faddr_cw) ||
                    (has_next_reg && {{(CW-ADDR_WIDTH){1'b0}}, next_s_reg} < f_end))
                begin
                    status_next = ST_BAD;
                end
                else
                begin
                    status_next   = ST_OK;
                    newtotal_next = total_sum[31:0];
                    if (has_prev_reg && prev_end == faddr_cw)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = IW'(pos_reg - CNT_ONE);
                        if (has_next_reg && {{(CW-ADDR_WIDTH){1'b0}}, next_s_reg} == f_end)
                        begin
                            // Bridge both neighbors, then drop the upper one
                            ram_wdata = {prev_s_reg,
                                         prev_len_reg + req_reg.req_size + next_len_reg};
                            newcount_next = count_reg - CNT_ONE;
                            sh_up_next    = 1'b0;
                            sh_dst_next   = IW'(pos_reg);
                            sh_n_next     = count_reg - CNT_ONE - pos_reg;
                            if (count_reg - CNT_ONE - pos_reg != '0)
                            begin
                                state_next = S_SHRD;
                            end
                        end
                        else
                        begin
                            ram_wdata = {prev_s_reg, prev_len_reg + req_reg.req_size};
                        end
                    end
                    else if (has_next_reg && {{(CW-ADDR_WIDTH){1'b0}}, next_s_reg} == f_end)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = IW'(pos_reg);
                        ram_wdata = {faddr_cw[ADDR_WIDTH-1:0], next_len_reg + req_reg.req_size};
                    end
                    else if (count_reg == CNT_MAX)
                    begin
                        status_next   = ST_FULL;
                        newtotal_next = total_reg;
                    end
                    else
                    begin
                        newcount_next = count_reg + CNT_ONE;
                        fin_we_next   = 1'b1;
                        fin_addr_next = IW'(pos_reg);
                        fin_data_next = {faddr_cw[ADDR_WIDTH-1:0], req_reg.req_size};
                        sh_up_next    = 1'b1;
                        sh_dst_next   = IW'(count_reg);
                        sh_n_next     = count_reg - pos_reg;
                        if (count_reg != pos_reg)
                        begin
                            state_next = S_SHRD;
                        end
                    end
                end
            end

            S_SHRD:
            begin
                ram_raddr  = sh_up_reg ? sh_dst_reg - IW'(1) : sh_dst_reg + IW'(1);
                state_next = S_SHWR;
            end

            S_SHWR:
            begin
                // Move one entry a slot up or down
                ram_we      = 1'b1;
                ram_waddr   = sh_dst_reg;
                ram_wdata   = ram_rdata;
                sh_dst_next = sh_up_reg ? sh_dst_reg - IW'(1) : sh_dst_reg + IW'(1);
                sh_n_next   = sh_n_reg - CNT_ONE;
                state_next  = (sh_n_reg == CNT_ONE) ? S_DONE : S_SHRD;
            end

            S_DONE:
            begin
                if (fin_we_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = fin_addr_reg;
                    ram_wdata = fin_data_reg;
                end
                fin_we_next = 1'b0;
                if (status_reg == ST_OK)
                begin
                    count_next = newcount_reg;
                    total_next = newtotal_reg;
                end
                done_next              = 1'b1;
                result_next.address    = (status_reg == ST_OK) ? addr_out_reg : 32'd0;
                result_next.status     = status_reg;
                result_next.total_free = (status_reg == ST_OK) ? newtotal_reg : total_reg;
                state_next             = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            total_reg  <= '0;
            done_reg   <= 1'b0;
            fin_we_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            total_reg  <= total_next;
            done_reg   <= done_next;
            fin_we_reg <= fin_we_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        newcount_reg <= newcount_next;
        newtotal_reg <= newtotal_next;
        status_reg   <= status_next;
        addr_out_reg <= addr_out_next;
        idx_reg      <= idx_next;
        n_reg        <= n_next;
        pos_reg      <= pos_next;
        cur_s_reg    <= cur_s_next;
        aligned_reg  <= aligned_next;
        end_reg      <= end_next;
        sum_reg      <= sum_next;
        prev_s_reg   <= prev_s_next;
        prev_len_reg <= prev_len_next;
        has_prev_reg <= has_prev_next;
        next_s_reg   <= next_s_next;
        next_len_reg <= next_len_next;
        has_next_reg <= has_next_next;
        sh_up_reg    <= sh_up_next;
        sh_dst_reg   <= sh_dst_next;
        sh_n_reg     <= sh_n_next;
        fin_addr_reg <= fin_addr_next;
        fin_data_reg <= fin_data_next;
        result_reg   <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("extent count beyond table depth");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy)
        else $error("result strobe while still busy");

    a_fail_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && result_reg.status != ST_OK) |->
        (count_reg == $past(count_reg) && total_reg == $past(total_reg) &&
         result_reg.address == 32'd0))
        else $error("failed request changed state");

    a_total_shown: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> result_reg.total_free == total_reg)
        else $error("reported free total differs from running total");
`endif

endmodule

FILE: bench/aea_checker.sv
`timescale 1ns / 1ps

module aea_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          busy,
    input  aea_pkg::req_t req,
    input  logic          done,
    input  aea_pkg::rsp_t result,
    output int            fail_count,
    output int            pending,
    output int            ok_count,
    output int            full_count
);
    import aea_pkg::*;

    localparam int DEPTH = 32;
    localparam logic [31:0] GMASK = 32'hF;

    logic [31:0] ext_base [DEPTH];
    logic [31:0] ext_len  [DEPTH];
    int          ext_num;
    logic [32:0] bytes_free;
    rsp_t        answers [$];

    assign pending = answers.size();

    function automatic void drop_at(int pos);
        for (int k = pos; k + 1 < ext_num; k++)
        begin
            ext_base[k] = ext_base[k + 1];
            ext_len[k]  = ext_len[k + 1];
        end
        ext_num--;
    endfunction

    function automatic void put_at(int pos, logic [31:0] b, logic [31:0] l);
        for (int k = ext_num; k > pos; k--)
        begin
            ext_base[k] = ext_base[k - 1];
            ext_len[k]  = ext_len[k - 1];
        end
        ext_base[pos] = b;
        ext_len[pos]  = l;
        ext_num++;
    endfunction

    function automatic logic [1:0] carve(bit from_top, logic [31:0] sz, logic [4:0] alog,
                                         output logic [31:0] addr);
        logic [63:0] al, s, pad, len, left, place;
        int i;
        bit hit;
        addr = '0;
        hit = 1'b0;
        i = 0;
        pad = '0;
        if (sz == 0 || (sz & GMASK) != 0 || alog < 4)
            return ST_BAD;
        al = 64'd1 << alog;
        for (int n = 0; n < ext_num; n++)
        begin
            i = from_top ? ext_num - 1 - n : n;
            s = 64'(ext_base[i]);
            pad = ((s + al - 1) & ~(al - 1)) - s;
            if (pad + sz <= ext_len[i])
            begin
                hit = 1'b1;
                break;
            end
        end
        if (!hit)
            return ST_NOFIT;
        s = 64'(ext_base[i]);
        len = 64'(ext_len[i]);
        place = s + pad;
        left = len - sz - pad;
        if (pad == 0)
        begin
            if (left > 0)
            begin
                ext_base[i] = 32'(place + sz);
                ext_len[i]  = left[31:0];
            end
            else
                drop_at(i);
        end
        else if (left > 0)
        begin
            if (ext_num >= DEPTH)
                return ST_FULL;
            ext_len[i] = pad[31:0];
            put_at(i + 1, 32'(place + sz), left[31:0]);
        end
        else
            ext_len[i] = pad[31:0];
        bytes_free -= sz;
        addr = place[31:0];
        return ST_OK;
    endfunction

    function automatic logic [1:0] give_back(logic [31:0] a, logic [31:0] sz);
        int pos;
        bit jp, jn;
        logic [63:0] a64, end64;
        pos = 0;
        a64 = 64'(a);
        end64 = a64 + sz;
        if (sz == 0 || (sz & GMASK) != 0 || (a & GMASK) != 0)
            return ST_BAD;
        if (end64 > 64'h1_0000_0000)
            return ST_BAD;
        if (bytes_free + sz > 33'hFFFF_FFFF)
            return ST_BAD;
        while (pos < ext_num && ext_base[pos] < a)
            pos++;
        if (pos > 0 && 64'(ext_base[pos - 1]) + ext_len[pos - 1] > a64)
            return ST_BAD;
        if (pos < ext_num && 64'(ext_base[pos]) < end64)
            return ST_BAD;
        jp = pos > 0 && 64'(ext_base[pos - 1]) + ext_len[pos - 1] == a64;
        jn = pos < ext_num && 64'(ext_base[pos]) == end64;
        if (jp && jn)
        begin
            ext_len[pos - 1] += sz + ext_len[pos];
            drop_at(pos);
        end
        else if (jp)
            ext_len[pos - 1] += sz;
        else if (jn)
        begin
            ext_base[pos] = a;
            ext_len[pos] += sz;
        end
        else
        begin
            if (ext_num >= DEPTH)
                return ST_FULL;
            put_at(pos, a, sz);
        end
        bytes_free += sz;
        return ST_OK;
    endfunction

    // Predict on every accepted request, compare on every strobe.
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t exp_r;
        rsp_t got;
        logic [31:0] a;
        if (!rst_n)
        begin
            ext_num = 0;
            bytes_free = '0;
            answers.delete();
            fail_count = 0;
            ok_count = 0;
            full_count = 0;
        end
        else
        begin
            if (done)
            begin
                got = result;
                if (answers.size() == 0)
                begin
                    $error("result with no request outstanding: %h", got);
                    fail_count++;
                end
                else
                begin
                    exp_r = answers.pop_front();
                    if (got.address !== exp_r.address)
                    begin
                        $error("address expected %h actual %h", exp_r.address, got.address);
                        fail_count++;
                    end
                    if (got.status !== exp_r.status)
                    begin
                        $error("status expected %0d actual %0d", exp_r.status, got.status);
                        fail_count++;
                    end
                    if (got.total_free !== exp_r.total_free)
                    begin
                        $error("total_free expected %h actual %h",
                               exp_r.total_free, got.total_free);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                a = '0;
                case (req.cmd)
                    CMD_ALLOC_FIRST: exp_r.status = carve(1'b0, req.req_size, req.align_log2, a);
                    CMD_ALLOC_LAST:  exp_r.status = carve(1'b1, req.req_size, req.align_log2, a);
                    CMD_FREE:        exp_r.status = give_back(req.free_address, req.req_size);
                    default:         exp_r.status = ST_BAD;
                endcase
                if (exp_r.status == ST_OK)
                    ok_count++;
                if (exp_r.status == ST_FULL)
                    full_count++;
                exp_r.address = (exp_r.status == ST_OK) ? a : '0;
                exp_r.total_free = bytes_free[31:0];
                answers.push_back(exp_r);
            end
        end
    end
endmodule

FILE: bench/tb_aligned_extent_allocator.sv
`timescale 1ns / 1ps

module tb_aligned_extent_allocator;
    import aea_pkg::*;

    logic          clk;
    logic          rst_n;
    logic          start;
    req_t          req;
    logic          busy;
    logic          done;
    rsp_t          result;
    int            fail_count;
    int            pending;
    int            ok_count;
    int            full_count;
    int            cycles;
    int            issued;

    // Local shadow of allocations still held, so frees can hand real blocks back.
    logic [31:0]   held_addr [$];
    logic [31:0]   held_size [$];

    aligned_extent_allocator uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .req    (req),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    aea_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req        (req),
        .done       (done),
        .result     (result),
        .fail_count (fail_count),
        .pending    (pending),
        .ok_count   (ok_count),
        .full_count (full_count)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog: reports a failure and stops if the run of 1550 requests overruns its bound.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 2_000_000)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Issue one request: hold start until busy is seen low after an edge, then drop start.
    // When it is an allocation, catch the returned address for later frees.
    task automatic send(logic [1:0] c, logic [31:0] sz, logic [4:0] al, logic [31:0] fa,
                        bit track);
        int gap;
        gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        repeat (gap) @(posedge clk);
        req   <= '{cmd: c, req_size: sz, align_log2: al, free_address: fa};
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        start <= 1'b0;
        issued++;
        // step off the edge that dropped start
        @(posedge clk);
        if (track && c != CMD_FREE)
        begin
            // wait for this request's strobe, sampled at the edge
            do
                @(posedge clk);
            while (!done);
            if (result.status == ST_OK)
            begin
                held_addr.push_back(result.address);
                held_size.push_back(sz);
            end
        end
    endtask

    // Hand back one held block, chosen at random, possibly in pieces.
    task automatic release_one();
        int idx;
        logic [31:0] a, s, part;
        idx = $urandom_range(0, held_addr.size() - 1);
        a = held_addr[idx];
        s = held_size[idx];
        held_addr.delete(idx);
        held_size.delete(idx);
        if (s > 32 && $urandom_range(0, 2) == 0)
        begin
            part = (($urandom_range(1, s / 16 - 1)) * 16);
            send(CMD_FREE, part, 5'd4, a + s - part, 1'b0);
            s = s - part;
        end
        send(CMD_FREE, s, 5'd4, a, 1'b0);
    endtask

    function automatic logic [31:0] rand_gsize();
        case ($urandom_range(0, 3))
            0: return 32'd16 * $urandom_range(1, 4);
            1: return 32'd16 * $urandom_range(1, 64);
            2: return 32'd16 * $urandom_range(1, 4096);
            default: return $urandom & ~32'hF;
        endcase
    endfunction

    initial
    begin
        logic [31:0] s;
        logic [1:0]  c;
        issued = 0;
        rst_n  = 1'b0;
        start  = 1'b0;
        req    = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, bad requests, unknown command, field extremes.
        send(CMD_ALLOC_FIRST, 32'd16, 5'd4, '0, 1'b0);
        send(CMD_ALLOC_FIRST, 32'd0, 5'd4, '0, 1'b0);
        send(CMD_ALLOC_LAST, 32'd24, 5'd4, '0, 1'b0);
        send(CMD_ALLOC_FIRST, 32'd16, 5'd3, '0, 1'b0);
        send(2'd3, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF, 1'b0);
        send(CMD_FREE, 32'd0, 5'd0, 32'h100, 1'b0);
        send(CMD_FREE, 32'd16, 5'd0, 32'h108, 1'b0);
        send(CMD_FREE, 32'h20, 5'd0, 32'hFFFF_FFF0, 1'b0);
        send(CMD_FREE, 32'h10, 5'd0, 32'hFFFF_FFF0, 1'b0);
        send(CMD_FREE, 32'h1000, 5'd0, 32'h0, 1'b0);
        send(CMD_FREE, 32'h100, 5'd0, 32'h800, 1'b0);
        send(CMD_FREE, 32'h10, 5'd0, 32'h810, 1'b0);
        send(CMD_FREE, 32'h100, 5'd0, 32'h1000, 1'b0);
        send(CMD_FREE, 32'h800, 5'd0, 32'h1800, 1'b0);
        send(CMD_FREE, 32'hFFFF_FFF0, 5'd0, 32'h10_0000, 1'b0);
        send(CMD_ALLOC_FIRST, 32'h10, 5'd31, '0, 1'b1);
        send(CMD_ALLOC_LAST, 32'h30, 5'd7, '0, 1'b1);
        send(CMD_ALLOC_FIRST, 32'h100, 5'd9, '0, 1'b1);
        send(CMD_ALLOC_FIRST, 32'hFFFF_FFF0, 5'd4, '0, 1'b1);
        send(CMD_ALLOC_LAST, 32'hFF0, 5'd4, '0, 1'b1);
        send(CMD_ALLOC_FIRST, 32'h2FF0, 5'd4, '0, 1'b1);

        // Pause until every outstanding result is back.
        while (pending != 0)
            @(posedge clk);

        // Fragment the table past its 32 entries: free many disjoint granules.
        for (int k = 0; k < 40; k++)
            send(CMD_FREE, 32'h10, 5'd0, 32'h4000_0000 + k * 32'h40, 1'b0);
        // A splitting allocation on a full table.
        send(CMD_ALLOC_FIRST, 32'h10, 5'd5, '0, 1'b1);

        // Random part: mostly well-formed alloc/free traffic, some noise.
        while (issued < 1550)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                    send(CMD_FREE, rand_gsize(), 5'($urandom),
                         ($urandom & 32'hFFFF_F000) | ($urandom_range(0, 255) << 4), 1'b0);
                3, 4, 5, 6:
                begin
                    c = 2'($urandom_range(0, 1));
                    s = ($urandom_range(0, 1)) ? rand_gsize() : 32'd16 * $urandom_range(1, 8);
                    send(c, s, 5'($urandom_range(4, $urandom_range(0, 3) == 0 ? 31 : 12)),
                         '0, 1'b1);
                end
                7, 8:
                    if (held_addr.size() != 0)
                        release_one();
                default:
                    send(2'($urandom), $urandom, 5'($urandom), $urandom, 1'b0);
            endcase
        end

        while (pending != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        $display("Covered %0d requests: %0d succeeded, %0d hit a full table.",
                 issued, ok_count, full_count);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
